@@ design/fvnh_pkg.sv @@
// Shared constants, types and the ease-weight function for the value-noise height block.
// No dependencies; every other file of the block imports this package.
package fvnh_pkg;

   localparam int OCTAVES_DEF = 6;
   localparam int WTB_DEF     = 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_GAIN  = 4'd0,
      CSR_HEIGHT_GAIN = 4'd1
   } csr_idx_type;

   localparam logic [15:0] SCALE_GAIN_RST  = 16'd1024;
   localparam logic [15:0] HEIGHT_GAIN_RST = 16'd3840;

   // hash constants
   localparam logic [31:0] HASH_K1 = 32'd15731;
   localparam logic [31:0] HASH_K2 = 32'd789221;
   localparam logic [31:0] HASH_K3 = 32'd1376312589;
   localparam logic [31:0] ROW_STRIDE = 32'd57;

   // coordinate offset of 64.0 in Q16.8
   localparam logic signed [24:0] COORD_OFS = 25'sd16384;

   localparam int COORD_W = 34;   // noise coordinate, signed Q.16
   localparam int VAL_W   = 18;   // lattice value, signed Q2.16
   localparam int WGT_W   = 17;   // blend weight, 0..65536
   localparam int SUM_W   = 20;   // octave sum
   localparam int HGT_W   = 27;   // result height

   // pipeline depth of one octave, from its input register to the noise output
   localparam int OCT_LAT = 7;

   localparam logic signed [HGT_W-1:0] HGT_MAX = 27'sd67108863;
   localparam logic signed [HGT_W-1:0] HGT_MIN = -27'sd67108864;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [WGT_W-1:0]        wgt_type;

   // sin^2(pi*u/2) in Q16 for 0 <= u <= 0.5, Q30 Taylor series to the 9th power
   function automatic wgt_type ease_low(input longint unsigned u);
      longint unsigned a, a2, p3, p5, p7, p9, s;
      a  = (u * 64'd1686629713) >> 16;
      a2 = (a * a) >> 30;
      p3 = (a * a2) >> 30;
      p5 = (p3 * a2) >> 30;
      p7 = (p5 * a2) >> 30;
      p9 = (p7 * a2) >> 30;
      s  = a - p3 / 64'd6 + p5 / 64'd120 - p7 / 64'd5040 + p9 / 64'd362880;
      return WGT_W'((s * s + (64'd1 << 43)) >> 44);
   endfunction

   // full cosine-ease weight, mirrored about one half
   function automatic wgt_type ease_weight(input longint unsigned u);
      if (u <= 64'd32768) begin
         return ease_low(u);
      end
      return WGT_W'(64'd65536 - 64'(ease_low(64'd65536 - u)));
   endfunction

endpackage

@@ design/fvnh_hash.sv @@
// Four-stage pipelined 32-bit integer lattice hash, giving a Q2.16 value.
// Depends on fvnh_pkg.
module fvnh_hash import fvnh_pkg::*; (
   input  logic        clock,
   input  logic [31:0] idx,
   output val_type     value
);

   logic [31:0] n_ff, n_in;
   logic [31:0] n2_ff, sq_ff, sq_in;
   logic [31:0] n3_ff, t_ff, t_in;
   logic [31:0] m_full;
   val_type     val_ff, val_in;

   // scramble the index
   assign n_in = (idx << 13) ^ idx;

   // square, then polynomial, then final product
   assign sq_in  = 32'(n_ff * n_ff);
   assign t_in   = 32'(sq_ff * HASH_K1) + HASH_K2;
   assign m_full = 32'(n3_ff * t_ff) + HASH_K3;
   assign val_in = VAL_W'(signed'(18'sd65536)) - signed'({1'b0, m_full[30:14]});

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      n2_ff  <= n_ff;
      sq_ff  <= sq_in;
      n3_ff  <= n2_ff;
      t_ff   <= t_in;
      val_ff <= val_in;
   end

   assign value = val_ff;

endmodule

@@ design/fvnh_octave.sv @@
// One octave of 2D value noise: lattice index, ease weights, four hashes and bilinear blend.
// Depends on fvnh_pkg and fvnh_hash.
module fvnh_octave import fvnh_pkg::*; #(
   parameter int SHIFT = 0,
   parameter int WTB   = WTB_DEF
) (
   input  logic                       clock,
   input  logic signed [COORD_W-1:0]  cx,
   input  logic signed [COORD_W-1:0]  cz,
   output val_type                    noise
);

   localparam int TAB_N = 1 << WTB;

   function automatic logic [TAB_N*WGT_W-1:0] build_tab();
      logic [TAB_N*WGT_W-1:0] t;
      t = '0;
      for (int k = 0; k < TAB_N; k++) begin
         t[k*WGT_W +: WGT_W] = ease_weight(64'(k) << (16 - WTB));
      end
      return t;
   endfunction

   localparam logic [TAB_N*WGT_W-1:0] WTAB = build_tab();

   logic [63:0]     ex, ez;
   logic [31:0]     ix, iz;
   logic [WTB-1:0]  kx, kz;
   logic [31:0]     base_ff, base_in;
   wgt_type         wx_ff [5];
   wgt_type         wz_ff [6];
   val_type         v [4];
   logic signed [VAL_W+WGT_W:0] r0, r1, rz;
   val_type         b0_ff, b1_ff, nz_ff;

   // scale by the octave and split into lattice index and fraction
   assign ex = 64'(cx) << SHIFT;
   assign ez = 64'(cz) << SHIFT;
   assign ix = ex[47:16];
   assign iz = ez[47:16];
   assign kx = ex[15:16-WTB];
   assign kz = ez[15:16-WTB];
   assign base_in = ix + 32'(iz * ROW_STRIDE);

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      wx_ff[0] <= WTAB[kx*WGT_W +: WGT_W];
      wz_ff[0] <= WTAB[kz*WGT_W +: WGT_W];
      for (int s = 1; s < 5; s++) begin
         wx_ff[s] <= wx_ff[s-1];
      end
      for (int s = 1; s < 6; s++) begin
         wz_ff[s] <= wz_ff[s-1];
      end
   end

   // four corners: +1 in x, +57 in z
   fvnh_hash u_h0 (.clock(clock), .idx(base_ff),               .value(v[0]));
   fvnh_hash u_h1 (.clock(clock), .idx(base_ff + 32'd1),       .value(v[1]));
   fvnh_hash u_h2 (.clock(clock), .idx(base_ff + ROW_STRIDE),  .value(v[2]));
   fvnh_hash u_h3 (.clock(clock), .idx(base_ff + ROW_STRIDE + 32'd1), .value(v[3]));

   function automatic logic signed [VAL_W+WGT_W:0] mix(input val_type a, input val_type b,
                                                        input wgt_type w);
      logic signed [VAL_W-1:0] wp, wn;
      wp = signed'({1'b0, w});
      wn = signed'(18'sd65536) - wp;
      return (VAL_W+WGT_W+1)'(a * wn) + (VAL_W+WGT_W+1)'(b * wp);
   endfunction

   // blend along x for both rows, then along z
   assign r0 = mix(v[0], v[1], wx_ff[4]);
   assign r1 = mix(v[2], v[3], wx_ff[4]);
   assign rz = mix(b0_ff, b1_ff, wz_ff[5]);

   always_ff @(posedge clock) begin
      b0_ff <= r0[VAL_W+15:16];
      b1_ff <= r1[VAL_W+15:16];
      nz_ff <= rz[VAL_W+15:16];
   end

   assign noise = nz_ff;

endmodule

@@ design/fractal_value_noise_height_top.sv @@
// Top level of the fractal value-noise height block: coordinate scaling, octaves, sum, gain.
// Depends on fvnh_pkg and fvnh_octave.
//
// Fully pipelined: a new word is taken on every cycle (busy stays low) and its
// height appears on rsp_height with rsp_valid high for one cycle, after the input,
// scaled-coordinate, octave, sum, gain and output registers. All octaves run side
// by side, each through its own four-stage hash and two-stage blend; the receiver
// cannot stall the pipeline.
// Write the gain registers only while no word is in flight.
module fractal_value_noise_height_top import fvnh_pkg::*; #(
   parameter int OCTAVES           = OCTAVES_DEF,
   parameter int WEIGHT_TABLE_BITS = WTB_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [23:0]       req_x_coord,
   input  logic signed [23:0]       req_z_coord,
   output logic                     rsp_valid,
   output logic signed [HGT_W-1:0]  rsp_height,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]              csr_data
);

   localparam int VLD_N = OCT_LAT + 5;

   logic [15:0] scale_ff, height_ff;
   logic [VLD_N-1:0] vld_ff;
   logic signed [23:0] x_ff, z_ff;
   logic signed [COORD_W-1:0] cx_ff, cz_ff;
   val_type noise [OCTAVES];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [36:0] hp;
   logic signed [28:0] h_ff, h_in;
   logic signed [HGT_W-1:0] out_ff, out_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers; other indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_GAIN_RST;
         height_ff <= HEIGHT_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE_GAIN:  scale_ff  <= csr_data;
            CSR_HEIGHT_GAIN: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VLD_N-2:0], start};
      end
   end

   // offset and scale the coordinates into Q.16
   always_ff @(posedge clock) begin
      x_ff  <= req_x_coord;
      z_ff  <= req_z_coord;
      cx_ff <= COORD_W'(((42'(x_ff) + 42'(COORD_OFS)) * signed'({1'b0, scale_ff})) >>> 7);
      cz_ff <= COORD_W'(((42'(z_ff) + 42'(COORD_OFS)) * signed'({1'b0, scale_ff})) >>> 7);
   end

   for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
      fvnh_octave #(.SHIFT(g), .WTB(WEIGHT_TABLE_BITS)) u_oct (
         .clock(clock), .cx(cx_ff), .cz(cz_ff), .noise(noise[g])
      );
   end

   // sum octaves with halving amplitude
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < OCTAVES; i++) begin
         sum_in = sum_in + (SUM_W'(noise[i]) >>> i);
      end
   end

   assign hp   = 37'(sum_ff) * signed'({1'b0, height_ff});
   assign h_in = hp[36:8];

   // saturate to the output range
   always_comb begin
      if (h_ff > 29'(HGT_MAX)) begin
         out_in = HGT_MAX;
      end else if (h_ff < 29'(HGT_MIN)) begin
         out_in = HGT_MIN;
      end else begin
         out_in = h_ff[HGT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      h_ff   <= h_in;
      out_ff <= out_in;
   end

   assign rsp_valid  = vld_ff[VLD_N-1];
   assign rsp_height = out_ff;

endmodule
